// File: hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk_i and held off in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The expression holds at every clock edge outside reset.
`define ASSERT_ALWAYS(label, expr, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (expr)) \
    else $error(msg);

// Whenever the antecedent holds, the consequent holds in the same cycle.
`define ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Whenever the antecedent holds, the consequent holds in the next cycle.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/gmd_pkg.sv
// ----------------------------------------------------------------------------
// gmd_pkg
// Types, constants and helpers of the greedy minimum-distance code builder.
// ----------------------------------------------------------------------------
package gmd_pkg;

  localparam int MaxWordLen = 32;
  localparam int CodeDepth  = 256;
  localparam int SymW       = 8;
  localparam int LenW       = 6;
  localparam int PosW       = $clog2(MaxWordLen);
  localparam int CntW       = $clog2(CodeDepth + 1);
  localparam int IdxW       = $clog2(CodeDepth);
  localparam int RowW       = MaxWordLen * SymW;
  localparam int FifoDepth  = 4;
  localparam int FifoPtrW   = $clog2(FifoDepth);
  localparam int FifoCntW   = $clog2(FifoDepth + 1);
  localparam int OutDataW   = 24;

  localparam logic OP_CLEAR  = 1'b0;
  localparam logic OP_SYMBOL = 1'b1;

  localparam logic CFG_MIN_DIST = 1'b0;
  localparam logic CFG_WORD_LEN = 1'b1;

  typedef enum logic {
    KIND_CLEAR,
    KIND_SYMBOL
  } kind_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_FINISH
  } back_state_e;

  typedef struct packed {
    logic [LenW-1:0] min_dist;
    logic [LenW-1:0] word_len;
  } cfg_t;

  typedef struct packed {
    kind_e           kind;
    logic [SymW-1:0] sym;
    logic [PosW-1:0] pos;
    logic            last;
  } q_entry_t;

  function automatic logic [LenW-1:0] eff_len(input logic [LenW-1:0] wl);
    logic [LenW-1:0] n;
    n = wl;
    if (n == '0) begin
      n = LenW'(1);
    end else if (n > LenW'(MaxWordLen)) begin
      n = LenW'(MaxWordLen);
    end
    return n;
  endfunction

endpackage

// File: hw/rtl/gmd_front.sv
// ----------------------------------------------------------------------------
// gmd_front
// Accepts input beats, tracks the symbol position and tags each queued
// command as a clear or as a symbol, marking the symbol that ends a word.
// ----------------------------------------------------------------------------
module gmd_front
  import gmd_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  cfg_t            cfg_i,
  input  logic            s_axis_tvalid,
  output logic            s_axis_tready,
  input  logic [SymW-1:0] s_axis_tdata,  // symbol[7:0]
  input  logic            s_axis_tuser,  // operation[0]
  output logic            push_o,
  output q_entry_t        entry_o,
  input  logic            full_i
);

  logic [LenW-1:0] pos_q, pos_d;
  logic [LenW-1:0] len;
  logic [LenW-1:0] pos_inc;
  logic            take;

  assign len           = eff_len(cfg_i.word_len);
  assign s_axis_tready = !full_i;
  assign take          = s_axis_tvalid && !full_i;
  assign pos_inc       = pos_q + LenW'(1);

  always_comb begin
    pos_d         = pos_q;
    entry_o.kind  = KIND_CLEAR;
    entry_o.sym   = s_axis_tdata;
    entry_o.pos   = pos_q[PosW-1:0];
    entry_o.last  = 1'b0;
    if (s_axis_tuser == OP_CLEAR) begin
      entry_o.kind = KIND_CLEAR;
    end else begin
      entry_o.kind = KIND_SYMBOL;
      entry_o.last = (pos_inc >= len);
    end
    if (take) begin
      if (entry_o.kind == KIND_CLEAR || entry_o.last) begin
        pos_d = '0;
      end else begin
        pos_d = pos_inc;
      end
    end
  end

  assign push_o = take;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
    end else begin
      pos_q <= pos_d;
    end
  end

endmodule

// File: hw/rtl/gmd_fifo.sv
// ----------------------------------------------------------------------------
// gmd_fifo
// Short command queue between the front and the back.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module gmd_fifo
  import gmd_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  q_entry_t data_i,
  output logic     full_o,
  output logic     valid_o,
  output q_entry_t data_o,
  input  logic     pop_i
);

  q_entry_t              store_q [FifoDepth];
  logic [FifoPtrW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [FifoCntW-1:0]   level_q;
  logic                  do_push, do_pop;

  assign full_o  = (level_q == FifoCntW'(FifoDepth));
  assign valid_o = (level_q != '0);
  assign data_o  = store_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      store_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      level_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + FifoPtrW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + FifoPtrW'(1);
      end
      if (do_push && !do_pop) begin
        level_q <= level_q + FifoCntW'(1);
      end else if (do_pop && !do_push) begin
        level_q <= level_q - FifoCntW'(1);
      end
    end
  end

  `ASSERT_ALWAYS(a_level_bound, level_q <= FifoCntW'(FifoDepth), "queue level overflow")
  `ASSERT_NEXT(a_push_lands, do_push && !do_pop, valid_o, "pushed entry not visible")

endmodule

// File: hw/rtl/gmd_back.sv
// ----------------------------------------------------------------------------
// gmd_back
// Loads candidate symbols, walks the codeword store one row per cycle to
// check the Hamming distance, appends passing words and registers results.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module gmd_back
  import gmd_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  cfg_t                cfg_i,
  input  logic                q_valid_i,
  input  q_entry_t            q_data_i,
  output logic                q_pop_o,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [OutDataW-1:0] m_axis_tdata  // accepted, rejected_full,
                                            // code_size[8:0], word_index[7:0]
);

  back_state_e       state_q, state_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic [CntW-1:0]   walk_q, walk_d;
  logic              rd_vld_q, rd_vld_d;
  logic              fail_q, fail_d;
  logic              rd_issue;
  logic              mem_we;
  logic              cand_we;

  logic [SymW-1:0]   cand_q [MaxWordLen];
  logic [RowW-1:0]   mem [CodeDepth];
  logic [RowW-1:0]   rdata_q;

  logic              out_valid_q, out_valid_d;
  logic              acc_q, acc_d;
  logic              full_q, full_d;
  logic [CntW-1:0]   size_q, size_d;
  logic [IdxW-1:0]   idx_q, idx_d;
  logic              out_load;

  logic [LenW-1:0]        len;
  logic [MaxWordLen-1:0]  mism;
  logic [LenW-1:0]        ham_dist;
  logic [CntW-1:0]        slot_next;

  assign len = eff_len(cfg_i.word_len);

  always_comb begin
    for (int l = 0; l < MaxWordLen; l++) begin
      mism[l] = (LenW'(l) < len) && (rdata_q[l*SymW +: SymW] != cand_q[l]);
    end
  end
  assign ham_dist = LenW'($countones(mism));

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    walk_d      = walk_q;
    rd_vld_d    = 1'b0;
    fail_d      = fail_q;
    rd_issue    = 1'b0;
    mem_we      = 1'b0;
    cand_we     = 1'b0;
    q_pop_o     = 1'b0;
    out_load    = 1'b0;
    acc_d       = acc_q;
    full_d      = full_q;
    size_d      = size_q;
    idx_d       = idx_q;
    case (state_q)
      ST_IDLE: begin
        if (q_valid_i) begin
          q_pop_o = 1'b1;
          if (q_data_i.kind == KIND_CLEAR) begin
            cnt_d = '0;
          end else begin
            cand_we = 1'b1;
            if (q_data_i.last) begin
              state_d = ST_WALK;
              walk_d  = '0;
              fail_d  = 1'b0;
            end
          end
        end
      end
      ST_WALK: begin
        if (walk_q < cnt_q) begin
          rd_issue = 1'b1;
          walk_d   = walk_q + CntW'(1);
        end
        rd_vld_d = rd_issue;
        if (rd_vld_q && (ham_dist < cfg_i.min_dist)) begin
          fail_d = 1'b1;
        end
        if (!rd_issue && !rd_vld_q) begin
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (!out_valid_q || m_axis_tready) begin
          out_load = 1'b1;
          acc_d    = 1'b0;
          full_d   = 1'b0;
          idx_d    = '0;
          if (!fail_q) begin
            if (cnt_q >= CntW'(CodeDepth)) begin
              full_d = 1'b1;
            end else begin
              mem_we = 1'b1;
              acc_d  = 1'b1;
              idx_d  = cnt_q[IdxW-1:0];
              cnt_d  = cnt_q + CntW'(1);
            end
          end
          size_d  = cnt_d;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      walk_q      <= '0;
      rd_vld_q    <= 1'b0;
      fail_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      walk_q      <= walk_d;
      rd_vld_q    <= rd_vld_d;
      fail_q      <= fail_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q  <= acc_d;
    full_q <= full_d;
    size_q <= size_d;
    idx_q  <= idx_d;
    if (cand_we) begin
      cand_q[q_data_i.pos] <= q_data_i.sym;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      for (int l = 0; l < MaxWordLen; l++) begin
        if (LenW'(l) < len) begin
          mem[cnt_q[IdxW-1:0]][l*SymW +: SymW] <= cand_q[l];
        end
      end
    end
    if (rd_issue) begin
      rdata_q <= mem[walk_q[IdxW-1:0]];
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {(OutDataW - IdxW - CntW - 2)'(0), idx_q, size_q, full_q, acc_q};
  assign slot_next     = CntW'(idx_q) + CntW'(1);

  `ASSERT_ALWAYS(a_count_bound, cnt_q <= CntW'(CodeDepth), "code size beyond store depth")
  `ASSERT_IMPLIES(a_flags_excl, out_valid_q, !(acc_q && full_q), "accepted and full both set")
  `ASSERT_IMPLIES(a_index_last, out_valid_q && acc_q, slot_next == size_q, "slot not last")
  `ASSERT_IMPLIES(a_walk_bound, state_q == ST_WALK, walk_q <= cnt_q, "store walk past code size")

endmodule

// File: hw/rtl/greedy_min_distance_code_builder.sv
// ----------------------------------------------------------------------------
// greedy_min_distance_code_builder
// Greedy lexicode builder with configuration registers, a command front,
// a command queue and a store-walking back end.
// ----------------------------------------------------------------------------
// Symbols enter a four-entry queue one beat per cycle while it is not full.
// A symbol that ends a word makes the back end walk the codeword store, one
// stored word per cycle through the store's read port, before its result beat
// is registered; other symbols and clears are taken while the back end is
// idle. The output register lets the next word load while a result beat waits.
// The user must write configuration only while no word is in flight; the block
// does not enforce it. The store needs no clearing pass after reset.
module greedy_min_distance_code_builder
  import gmd_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic                cfg_idx_i,
  input  logic [LenW-1:0]     cfg_data_i,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [SymW-1:0]     s_axis_tdata,  // symbol[7:0]
  input  logic                s_axis_tuser,  // operation[0]
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [OutDataW-1:0] m_axis_tdata   // accepted[0], rejected_full[1],
                                             // code_size[10:2], word_index[18:11]
);

  cfg_t     cfg_q;
  logic     push;
  logic     full;
  q_entry_t push_entry;
  logic     q_valid;
  q_entry_t q_data;
  logic     q_pop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.min_dist <= LenW'(1);
      cfg_q.word_len <= LenW'(8);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_MIN_DIST: cfg_q.min_dist <= cfg_data_i;
        CFG_WORD_LEN: cfg_q.word_len <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  gmd_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .push_o        (push),
    .entry_o       (push_entry),
    .full_i        (full)
  );

  gmd_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_entry),
    .full_o  (full),
    .valid_o (q_valid),
    .data_o  (q_data),
    .pop_i   (q_pop)
  );

  gmd_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .q_valid_i     (q_valid),
    .q_data_i      (q_data),
    .q_pop_o       (q_pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

endmodule
